@@ sv/npr_pkg.sv @@
// ----------------------------------------------------------------------------
// npr_pkg
// Shared types, codes and helpers for the NAND page read sequencer.
// ----------------------------------------------------------------------------
package npr_pkg;

    localparam int PAGE_BYTES_DEF = 2048;

    // page bits carried on the address cycles (three bytes)
    localparam int PAGE_W    = 24;
    localparam int BURST_MAX = 8;
    localparam int CNT_W     = 4;

    // input item kinds
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    // result actions
    localparam logic [2:0] ACT_SELECT   = 3'd0;
    localparam logic [2:0] ACT_CMD      = 3'd1;
    localparam logic [2:0] ACT_ADDR     = 3'd2;
    localparam logic [2:0] ACT_DATA     = 3'd3;
    localparam logic [2:0] ACT_DESELECT = 3'd4;

    localparam logic [7:0] CMD_READ    = 8'h00;
    localparam logic [7:0] CMD_CONFIRM = 8'h30;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] start_address;
        logic [31:0] byte_count;
        logic        ready_req;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] value;
    } entry_t;

    typedef entry_t [6:0] seq_t;

    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        entry_t [BURST_MAX-1:0]   ents;
    } burst_t;

    // read command, five address cycles, confirm; element 0 goes out first
    function automatic seq_t read_seq(input logic [15:0] col,
                                      input logic [PAGE_W-1:0] page);
        seq_t s;
        s[0] = '{action: ACT_CMD,  value: CMD_READ};
        s[1] = '{action: ACT_ADDR, value: col[7:0]};
        s[2] = '{action: ACT_ADDR, value: col[15:8]};
        s[3] = '{action: ACT_ADDR, value: page[7:0]};
        s[4] = '{action: ACT_ADDR, value: page[15:8]};
        s[5] = '{action: ACT_ADDR, value: page[23:16]};
        s[6] = '{action: ACT_CMD,  value: CMD_CONFIRM};
        return s;
    endfunction

endpackage

@@ sv/npr_decode.sv @@
// ----------------------------------------------------------------------------
// npr_decode
// Next-state and result burst for one item against the sequencer state.
// ----------------------------------------------------------------------------
module npr_decode #(
    parameter int PAGE_BYTES = npr_pkg::PAGE_BYTES_DEF
) (
    input  npr_pkg::item_t                  item,
    input  npr_pkg::phase_t                 phase,
    input  logic [npr_pkg::PAGE_W-1:0]      page,
    input  logic [$clog2(PAGE_BYTES)-1:0]   col,
    input  logic [31:0]                     remain,
    output npr_pkg::phase_t                 phase_next,
    output logic [npr_pkg::PAGE_W-1:0]      page_next,
    output logic [$clog2(PAGE_BYTES)-1:0]   col_next,
    output logic [31:0]                     remain_next,
    output npr_pkg::burst_t                 burst
);

    localparam int COL_W = $clog2(PAGE_BYTES);

    logic [COL_W:0]               col_inc;
    logic [31:0]                  remain_dec;
    logic [COL_W-1:0]             start_col;
    logic [npr_pkg::PAGE_W-1:0]   start_page;
    logic [npr_pkg::PAGE_W-1:0]   page_inc;

    assign col_inc    = {1'b0, col} + {{COL_W{1'b0}}, 1'b1};
    assign remain_dec = remain - 32'd1;
    assign start_col  = item.start_address[COL_W-1:0];
    assign start_page = npr_pkg::PAGE_W'(item.start_address >> COL_W);
    assign page_inc   = page + {{(npr_pkg::PAGE_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        phase_next  = phase;
        page_next   = page;
        col_next    = col;
        remain_next = remain;
        burst       = '0;
        case (item.op)
            npr_pkg::OP_START:
            begin
                if (phase == npr_pkg::PH_IDLE)
                begin
                    page_next   = start_page;
                    col_next    = start_col;
                    remain_next = item.byte_count;
                    burst.ents[0] = '{action: npr_pkg::ACT_SELECT, value: 8'h00};
                    if (item.byte_count == 32'd0)
                    begin
                        burst.ents[1] = '{action: npr_pkg::ACT_DESELECT, value: 8'h00};
                        burst.cnt     = npr_pkg::CNT_W'(2);
                    end
                    else
                    begin
                        burst.ents[7:1] = npr_pkg::read_seq(16'(start_col), start_page);
                        burst.cnt       = npr_pkg::CNT_W'(npr_pkg::BURST_MAX);
                        phase_next      = npr_pkg::PH_WAIT;
                    end
                end
            end
            npr_pkg::OP_STATUS:
            begin
                if (phase == npr_pkg::PH_WAIT && item.ready_req)
                    phase_next = npr_pkg::PH_DATA;
            end
            npr_pkg::OP_DATA:
            begin
                if (phase == npr_pkg::PH_DATA)
                begin
                    burst.ents[0] = '{action: npr_pkg::ACT_DATA, value: item.data_byte};
                    remain_next   = remain_dec;
                    col_next      = col_inc[COL_W-1:0];
                    if (remain_dec == 32'd0)
                    begin
                        burst.ents[1] = '{action: npr_pkg::ACT_DESELECT, value: 8'h00};
                        burst.cnt     = npr_pkg::CNT_W'(2);
                        phase_next    = npr_pkg::PH_IDLE;
                    end
                    else if (col_inc[COL_W])
                    begin
                        // page end: next page from column zero
                        page_next       = page_inc;
                        col_next        = '0;
                        burst.ents[7:1] = npr_pkg::read_seq(16'h0000, page_inc);
                        burst.cnt       = npr_pkg::CNT_W'(npr_pkg::BURST_MAX);
                        phase_next      = npr_pkg::PH_WAIT;
                    end
                    else
                    begin
                        burst.cnt = npr_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                phase_next = phase;
            end
        endcase
    end

endmodule

@@ sv/npr_emit.sv @@
// ----------------------------------------------------------------------------
// npr_emit
// Result register: holds one burst and shifts it out a transaction a cycle while m_tready is high.
// ----------------------------------------------------------------------------
module npr_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_req,
    input  npr_pkg::burst_t   burst,
    input  logic              m_tready,
    output logic              m_tvalid,
    output npr_pkg::entry_t   head,
    output logic              head_last,
    output logic              can_load
);

    logic [npr_pkg::CNT_W-1:0]              cnt_reg;
    npr_pkg::entry_t [npr_pkg::BURST_MAX-1:0] ents_reg;
    npr_pkg::entry_t [npr_pkg::BURST_MAX-1:0] ents_shift;
    logic                                   fire;
    logic                                   load;

    assign m_tvalid  = (cnt_reg != '0);
    assign head      = ents_reg[0];
    assign head_last = (cnt_reg == npr_pkg::CNT_W'(1));
    assign fire      = m_tvalid && m_tready;
    // free now, or the last entry leaves this cycle
    assign can_load  = (cnt_reg == '0) || (head_last && m_tready);
    assign load      = load_req && can_load && (burst.cnt != '0);

    always_comb
    begin
        ents_shift = ents_reg;
        for (int i = 0; i < npr_pkg::BURST_MAX - 1; i++)
            ents_shift[i] = ents_reg[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= burst.cnt;
        else if (fire)
            cnt_reg <= cnt_reg - npr_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ents_reg <= burst.ents;
        else if (fire)
            ents_reg <= ents_shift;
    end

endmodule

@@ sv/nand_page_read_sequencer.sv @@
// ----------------------------------------------------------------------------
// nand_page_read_sequencer
// Large-page NAND read sequencer: turns start, status and data transactions
// into chip select, command, address, data and deselect transactions.
// ----------------------------------------------------------------------------
// A start transaction (tuser 0) carries a byte address and count; the block
// answers with chip select, command 00h, five address bytes (column low,
// column high, page bits 7:0, 15:8, 23:16) and command 30h, then waits for
// a status transaction (tuser 1) with ready set. Each data transaction
// (tuser 2) is passed on as a delivered byte. At a page end with bytes still
// owed the read sequence goes out again for the next page at column zero;
// when the count is spent a deselect follows. A zero count gives select and
// deselect only. Transactions that do not fit the current phase, and tuser 3,
// produce nothing. tlast marks the final output caused by one input.
// Rate: one input per cycle while the output side accepts. Each input passes
// an input register, one level of decode logic and lands in an eight-entry
// result register, which drains one output per cycle while m_tready is high;
// a mid-page data byte (one output) thus streams at one per cycle, while a
// start or a page change (eight outputs) holds the next input until the last
// of its outputs leaves. PAGE_BYTES must be a power of two.
module nand_page_read_sequencer #(
    parameter int PAGE_BYTES = npr_pkg::PAGE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] start_address, [63:32] byte_count, [64] ready_req,
    // [72:65] data_byte, [79:73] zero
    input  logic [79:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] action, [10:3] value, [15:11] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam int COL_W = $clog2(PAGE_BYTES);

    // input register
    logic            in_valid_reg;
    npr_pkg::item_t  in_item_reg;
    npr_pkg::item_t  in_item;

    // sequencer state
    npr_pkg::phase_t              phase_reg;
    npr_pkg::phase_t              phase_next;
    logic [npr_pkg::PAGE_W-1:0]   page_reg;
    logic [npr_pkg::PAGE_W-1:0]   page_next;
    logic [COL_W-1:0]             col_reg;
    logic [COL_W-1:0]             col_next;
    logic [31:0]                  remain_reg;
    logic [31:0]                  remain_next;

    npr_pkg::burst_t  burst;
    npr_pkg::entry_t  head;
    logic             head_last;
    logic             can_load;
    logic             take;

    assign in_item.op            = s_tuser;
    assign in_item.start_address = s_tdata[31:0];
    assign in_item.byte_count    = s_tdata[63:32];
    assign in_item.ready_req     = s_tdata[64];
    assign in_item.data_byte     = s_tdata[72:65];

    // held item is consumed once the result register can take its burst
    assign take     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= in_item;
    end

    npr_decode #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_decode (
        .item        (in_item_reg),
        .phase       (phase_reg),
        .page        (page_reg),
        .col         (col_reg),
        .remain      (remain_reg),
        .phase_next  (phase_next),
        .page_next   (page_next),
        .col_next    (col_next),
        .remain_next (remain_next),
        .burst       (burst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= npr_pkg::PH_IDLE;
            page_reg   <= '0;
            col_reg    <= '0;
            remain_reg <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            page_reg   <= page_next;
            col_reg    <= col_next;
            remain_reg <= remain_next;
        end
    end

    npr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_req  (take),
        .burst     (burst),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .head      (head),
        .head_last (head_last),
        .can_load  (can_load)
    );

    assign m_tdata = {5'b00000, head.value, head.action};
    assign m_tlast = head_last;

`ifndef ASSERT_OFF
    // an open read always has bytes owed
    a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != npr_pkg::PH_IDLE |-> remain_reg != 32'd0)
        else $error("active phase with no bytes remaining");

    // confirm command closes its burst
    a_confirm_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == npr_pkg::ACT_CMD
            && m_tdata[10:3] == npr_pkg::CMD_CONFIRM |-> m_tlast)
        else $error("confirm command not last of its burst");

    // deselect closes its burst
    a_deselect_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == npr_pkg::ACT_DESELECT |-> m_tlast)
        else $error("deselect not last of its burst");
`endif

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NAND page read sequencer.
// ----------------------------------------------------------------------------
// A directed table comes first. It covers misplaced and unused transactions,
// zero counts, the highest address, page crossings and a count that ends
// exactly on a page end. Whole random read jobs follow, with noise mixed in.
// A bench-side copy of the sequencer state predicts every output
// transaction, and the monitor checks each output against the oldest one
// still owed. Idling runs in four phases on both sides. The receiver holds
// off once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] PAGE        = 32'(npr_pkg::PAGE_BYTES_DEF);
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          ITEM_GOAL   = 370;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN       = 40;
    localparam int          LIMIT_NS    = 5_000_000;
    localparam int          PREDICT     = -1;
    localparam int          N_SCRIPT    = 26;

    // one output transaction as seen on the master side
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] value;
        logic       last;
    } bus_op_t;

    typedef bus_op_t [0:1] pair_t;

    // directed row: one input transaction plus, where obvious, its outputs
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] cnt;
        logic        rdy;
        logic [7:0]  dat;
        int          n_typed;   // PREDICT: take the outputs from the predictor
        pair_t       typed;
    } vec_t;

    localparam bus_op_t SEL_OP    = '{npr_pkg::ACT_SELECT, 8'h00, 1'b0};
    localparam bus_op_t DESEL_END = '{npr_pkg::ACT_DESELECT, 8'h00, 1'b1};
    localparam pair_t   NO_OPS    = '0;
    localparam pair_t   SEL_DESEL = '{SEL_OP, DESEL_END};

    localparam vec_t SCRIPT [N_SCRIPT] = '{
        // misplaced and unused transactions straight after reset
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'h5A, 0, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b1, 8'h00, 0, NO_OPS},
        '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 0, NO_OPS},
        // zero count: select and deselect only, at both address extremes
        '{npr_pkg::OP_START,  32'h0, 32'h0, 1'b0, 8'h00, 2, SEL_DESEL},
        '{npr_pkg::OP_START,  32'hFFFF_FFFF, 32'h0, 1'b0, 8'h00, 2, SEL_DESEL},
        // last column of the highest page, two bytes: crosses into page 200000h
        '{npr_pkg::OP_START,  32'hFFFF_FFFF, 32'h2, 1'b0, 8'h00, PREDICT, NO_OPS},
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'hC3, 0, NO_OPS},
        '{npr_pkg::OP_START,  32'h0, 32'hFFFF_FFFF, 1'b1, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b0, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b1, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b1, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_START,  32'h1234_5678, 32'h5, 1'b0, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'hFF, PREDICT, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b1, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'h00, 2,
          '{'{npr_pkg::ACT_DATA, 8'h00, 1'b0}, DESEL_END}},
        // count runs out exactly on the page end: no new read sequence
        '{npr_pkg::OP_START,  32'h0000_07FE, 32'h2, 1'b0, 8'h00, PREDICT, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b1, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'hA5, 1,
          '{'{npr_pkg::ACT_DATA, 8'hA5, 1'b1}, '0}},
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'h5A, 2,
          '{'{npr_pkg::ACT_DATA, 8'h5A, 1'b0}, DESEL_END}},
        // single byte at page 1, unused op during the data phase
        '{npr_pkg::OP_START,  32'h0000_0800, 32'h1, 1'b0, 8'h00, PREDICT, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b1, 8'h00, 0, NO_OPS},
        '{OP_UNUSED, 32'h0, 32'h0, 1'b0, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'h3C, 2,
          '{'{npr_pkg::ACT_DATA, 8'h3C, 1'b0}, DESEL_END}},
        // first column of the highest page
        '{npr_pkg::OP_START,  32'hFFFF_F800, 32'h1, 1'b0, 8'h00, PREDICT, NO_OPS},
        '{npr_pkg::OP_STATUS, 32'h0, 32'h0, 1'b1, 8'h00, 0, NO_OPS},
        '{npr_pkg::OP_DATA,   32'h0, 32'h0, 1'b0, 8'h81, 2,
          '{'{npr_pkg::ACT_DATA, 8'h81, 1'b0}, DESEL_END}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // bench copy of the sequencer state
    npr_pkg::phase_t nand_phase = npr_pkg::PH_IDLE;
    logic [31:0]     cur_page   = '0;
    logic [31:0]     cur_col    = '0;
    logic [31:0]     bytes_owed = '0;

    bus_op_t fresh_ops [$];     // outputs caused by the latest input transaction
    bus_op_t owed_ops [$];      // outputs still to appear on the master side
    bit      took_effect;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_requests = 0;

    int faults          = 0;
    int work_items      = 0;
    int ignored_items   = 0;
    int starts_taken    = 0;
    int page_turns      = 0;
    int bytes_delivered = 0;
    int outputs_seen    = 0;

    nand_page_read_sequencer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout: %0d outputs still owed", owed_ops.size());
        $display("[nand_page_read_sequencer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void add_op(input logic [2:0] act, input logic [7:0] val);
        bus_op_t op;
        op = '{act, val, 1'b0};
        fresh_ops.push_back(op);
    endfunction

    // read command, column low/high, page bytes 0..2, confirm
    function automatic void add_page_read();
        add_op(npr_pkg::ACT_CMD, npr_pkg::CMD_READ);
        add_op(npr_pkg::ACT_ADDR, cur_col[7:0]);
        add_op(npr_pkg::ACT_ADDR, cur_col[15:8]);
        add_op(npr_pkg::ACT_ADDR, cur_page[7:0]);
        add_op(npr_pkg::ACT_ADDR, cur_page[15:8]);
        add_op(npr_pkg::ACT_ADDR, cur_page[23:16]);
        add_op(npr_pkg::ACT_CMD, npr_pkg::CMD_CONFIRM);
    endfunction

    // Outputs caused by one input transaction; updates the bench state.
    function automatic void flash_bus_ops(input logic [1:0] op, input logic [31:0] addr,
                                          input logic [31:0] cnt, input logic rdy,
                                          input logic [7:0] dat);
        fresh_ops.delete();
        took_effect = 1'b0;
        case (op)
            npr_pkg::OP_START:
                if (nand_phase == npr_pkg::PH_IDLE)
                begin
                    took_effect = 1'b1;
                    starts_taken++;
                    cur_page   = addr / PAGE;
                    cur_col    = addr % PAGE;
                    bytes_owed = cnt;
                    add_op(npr_pkg::ACT_SELECT, 8'h00);
                    if (cnt == 0)
                        add_op(npr_pkg::ACT_DESELECT, 8'h00);
                    else
                    begin
                        add_page_read();
                        nand_phase = npr_pkg::PH_WAIT;
                    end
                end
            npr_pkg::OP_STATUS:
                if (nand_phase == npr_pkg::PH_WAIT)
                begin
                    took_effect = 1'b1;
                    if (rdy)
                        nand_phase = npr_pkg::PH_DATA;
                end
            npr_pkg::OP_DATA:
                if (nand_phase == npr_pkg::PH_DATA)
                begin
                    took_effect = 1'b1;
                    add_op(npr_pkg::ACT_DATA, dat);
                    bytes_owed--;
                    cur_col++;
                    if (bytes_owed == 0)
                    begin
                        add_op(npr_pkg::ACT_DESELECT, 8'h00);
                        nand_phase = npr_pkg::PH_IDLE;
                    end
                    else if (cur_col >= PAGE)
                    begin
                        // page end with bytes still owed: reissue for next page
                        cur_page++;
                        cur_col = '0;
                        page_turns++;
                        add_page_read();
                        nand_phase = npr_pkg::PH_WAIT;
                    end
                end
            default: ;
        endcase
        if (fresh_ops.size() != 0)
            fresh_ops[fresh_ops.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Slave side: one transaction, with optional idle cycles ahead of it.
    // tvalid is left high after the handshake; the next call decides whether
    // it drops, so it never gets two assignments in one step.
    // ------------------------------------------------------------------------
    task automatic drive_item(input logic [1:0] op, input logic [31:0] addr,
                              input logic [31:0] cnt, input logic rdy,
                              input logic [7:0] dat);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, dat, rdy, cnt, addr};
        do
            @(posedge clk);
        while (!s_tready);
        flash_bus_ops(op, addr, cnt, rdy, dat);
        if (took_effect)
            work_items++;
        else
            ignored_items++;
    endtask

    task automatic offer(input logic [1:0] op, input logic [31:0] addr,
                         input logic [31:0] cnt, input logic rdy, input logic [7:0] dat);
        drive_item(op, addr, cnt, rdy, dat);
        foreach (fresh_ops[i])
            owed_ops.push_back(fresh_ops[i]);
    endtask

    // any op that the current phase ignores, with random content
    task automatic offer_noise();
        logic [1:0] proper;
        logic [1:0] op;
        proper = (nand_phase == npr_pkg::PH_IDLE) ? npr_pkg::OP_START :
                 (nand_phase == npr_pkg::PH_WAIT) ? npr_pkg::OP_STATUS : npr_pkg::OP_DATA;
        do
            op = 2'($urandom_range(3));
        while (op == proper);
        offer(op, $urandom, $urandom, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // start, then busy/ready statuses and data bytes until the count is spent
    task automatic read_job(input logic [31:0] addr, input logic [31:0] cnt);
        if ($urandom_range(5) == 0)
            offer_noise();
        offer(npr_pkg::OP_START, addr, cnt, 1'($urandom_range(1)), 8'($urandom_range(255)));
        while (nand_phase != npr_pkg::PH_IDLE)
        begin
            if ($urandom_range(9) == 0)
                offer_noise();
            else if (nand_phase == npr_pkg::PH_WAIT)
                offer(npr_pkg::OP_STATUS, $urandom, $urandom, 1'($urandom_range(3) != 0),
                      8'($urandom_range(255)));
            else
                offer(npr_pkg::OP_DATA, $urandom, $urandom, 1'($urandom_range(1)),
                      8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Master side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && served != hold_requests)
            begin
                served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic void note_fault(input string msg);
        if (faults < 10)
            $display("%0t ns: %s", $realtime, msg);
        faults++;
    endfunction

    always @(posedge clk)
    begin : monitor
        bus_op_t got;
        bus_op_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[2:0], m_tdata[10:3], m_tlast};
            if (owed_ops.size() == 0)
                note_fault($sformatf("unexpected output: action %0d value %02h last %0b",
                                     got.action, got.value, got.last));
            else
            begin
                want = owed_ops.pop_front();
                if (got.action !== want.action || got.value !== want.value ||
                    got.last !== want.last)
                    note_fault($sformatf({"output %0d: expected action %0d value %02h ",
                                          "last %0b, got action %0d value %02h last %0b"},
                                         outputs_seen, want.action, want.value, want.last,
                                         got.action, got.value, got.last));
                if (got.action == npr_pkg::ACT_DATA)
                    bytes_delivered++;
            end
            outputs_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          k;
        int          sent;
        logic [31:0] addr;
        logic [31:0] cnt;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        foreach (SCRIPT[i])
        begin
            drive_item(SCRIPT[i].op, SCRIPT[i].addr, SCRIPT[i].cnt, SCRIPT[i].rdy,
                       SCRIPT[i].dat);
            if (SCRIPT[i].n_typed == PREDICT)
            begin
                foreach (fresh_ops[j])
                    owed_ops.push_back(fresh_ops[j]);
            end
            else
            begin
                for (int j = 0; j < SCRIPT[i].n_typed; j++)
                    owed_ops.push_back(SCRIPT[i].typed[j]);
            end
        end

        // long receiver hold-off while a 40-byte job keeps the slave side busy
        hold_requests++;
        read_job(32'h0001_0000, 32'd40);

        sent = work_items + ignored_items;
        while (sent < ITEM_GOAL)
        begin
            if (sent < 140)
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            else if (sent < 220)
            begin
                src_idle_pct  = 83;
                snk_stall_pct = 0;
            end
            else if (sent < 300)
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 83;
            end
            else
            begin
                src_idle_pct  = 35;
                snk_stall_pct = 35;
            end

            k = $urandom_range(9);
            if (k == 0)
            begin
                addr = $urandom;
                cnt  = '0;
            end
            else if (k <= 3)
            begin
                // a few bytes short of a page end; sometimes ends right on it
                k    = $urandom_range(1, 8);
                addr = ($urandom & ~(PAGE - 1)) | (PAGE - 32'(k));
                cnt  = (($urandom_range(2) == 0) ? 32'(k) : 32'(k + $urandom_range(1, 12)));
            end
            else
            begin
                addr = $urandom;
                cnt  = 32'($urandom_range(1, 24));
            end
            read_job(addr, cnt);
            sent = work_items + ignored_items;
        end

        // huge count from the top address: crosses into page 200000h and is
        // left running, since it can never finish
        offer(npr_pkg::OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        repeat (12)
        begin
            if (nand_phase == npr_pkg::PH_WAIT)
                offer(npr_pkg::OP_STATUS, $urandom, $urandom, 1'b1,
                      8'($urandom_range(255)));
            else
                offer(npr_pkg::OP_DATA, $urandom, $urandom, 1'($urandom_range(1)),
                      8'($urandom_range(255)));
        end

        s_tvalid <= 1'b0;
        while (owed_ops.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("run: %0d working transactions, %0d ignored, %0d reads started",
                 work_items, ignored_items, starts_taken);
        $display("     %0d page turns, %0d bytes delivered, %0d outputs, %0d mismatches",
                 page_turns, bytes_delivered, outputs_seen, faults);
        if (faults == 0)
            $display("[nand_page_read_sequencer] OK");
        else
            $display("[nand_page_read_sequencer] ERROR");
        $finish;
    end

endmodule
